@@ sv/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the buddy bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_NOBLOCK = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int unsigned HDR_BYTES = 8;

endpackage

@@ sv/bba_divider.sv @@
// ----------------------------------------------------------------------------
// bba_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bba_divider #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_quot, n_quot;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_sh;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[DW-1:0], r_quot[NW-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem  = w_sh - {1'b0, r_den};
                n_quot = {r_quot[NW-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_quot = {r_quot[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

@@ sv/buddy_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// buddy_bitmap_allocator_core
// buddy allocator over a heap-numbered tree of free bits held in a memory
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and exactly one
// result strobe follows. The free map is a 2^LEVELS x 1 memory with one
// registered read port; after reset a clearing pass writes every entry to
// free (busy high, config writes still taken). Timing is set by the one
// memory port: an allocate runs the serial divider, then scans the free
// map downward, then marks the found node and each ancestor used and
// writes the subtree (read-free writes, one per cycle). A free walks up
// with one read per level and then marks its subtree. Invalid frees and
// failed allocates finish without writing the free map. The receiver
// cannot stall: the result is on the o_ ports for one cycle while
// o_valid is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buddy_bitmap_allocator_core #(
    parameter int unsigned LEVELS = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_op,
    input  logic [31:0]         i_request_bytes,
    input  logic [LEVELS-1:0]   i_free_node,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [LEVELS-1:0]   o_node_index,
    output logic [3:0]          o_block_level,
    output logic [23:0]         o_block_offset
);
    localparam int unsigned NN = 1 << LEVELS;
    localparam int unsigned NW = 16 + LEVELS;
    localparam int unsigned LW = 4;
    localparam int unsigned PW = $clog2(NW);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_SCAN  = 10'b0000001000,
        S_ANC   = 10'b0000010000,
        S_SUB   = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_WCHK  = 10'b0010000000,
        S_OFF   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state;

    // free map memory
    logic mem [NN];
    logic              w_we, w_wd, r_rd;
    logic [LEVELS-1:0] w_wa, w_ra;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rd <= mem[w_ra];
    end

    logic [15:0]       r_minb;
    logic              r_op;
    logic [31:0]       r_bytes;
    logic [LEVELS-1:0] r_node, r_cur, r_found;
    logic [LEVELS:0]   r_cnt;
    logic [LW-1:0]     r_lvl, r_k;
    logic              r_rdv;
    logic [1:0]        r_status;
    logic [47:0]       r_off;
    logic              r_div_go;
    logic              w_div_done;
    logic [NW-1:0]     w_quot;
    logic              r_val;
    logic              w_sub_val;

    bba_divider #(.NW(NW), .DW(33)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({r_minb, LEVELS'(0)}),
        .i_den   ({1'b0, r_bytes} + 33'(bba_pkg::HDR_BYTES)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // floor log2 of the quotient
    function automatic logic [PW-1:0] msb_pos(input logic [NW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < NW; i++) if (v[i]) p = PW'(i);
        return p;
    endfunction

    // level of a node index
    function automatic logic [LW-1:0] node_lvl(input logic [LEVELS-1:0] v);
        logic [LW-1:0] p;
        p = '0;
        for (int i = 0; i < LEVELS; i++) if (v[i]) p = LW'(i);
        return p;
    endfunction

    logic [PW-1:0]     w_qmsb;
    logic [LW-1:0]     w_qlvl;
    logic [LW-1:0]     w_sub_lvl;
    logic [LEVELS-1:0] w_sub_addr;
    assign w_qmsb = msb_pos(w_quot);
    assign w_qlvl = (w_qmsb > PW'(LEVELS-1)) ? LW'(LEVELS-1) : w_qmsb[LW-1:0];
    // subtree walk: level k below node, index r_cnt within that level
    assign w_sub_lvl  = node_lvl(r_node) + r_k;
    assign w_sub_addr = LEVELS'((NW'(r_node) << r_k) + NW'(r_cnt));

    always_comb begin
        w_we = 1'b0;
        w_wd = 1'b0;
        w_wa = '0;
        w_ra = r_cur;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1; w_wd = 1'b1; w_wa = r_cnt[LEVELS-1:0];
            end
            S_SUB: begin
                w_we = 1'b1; w_wd = r_op; w_wa = w_sub_addr;
            end
            S_ANC: begin
                w_we = 1'b1; w_wd = 1'b0; w_wa = r_cur;
            end
            S_WALK: begin
                w_we = 1'b1; w_wd = 1'b1; w_wa = r_cur;
                w_ra = r_cur ^ LEVELS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_div_go <= i_rst_n && r_state == S_IDLE && start && i_op == bba_pkg::OP_ALLOC;
        r_val    <= i_rst_n && r_state == S_DONE;
        // read issued in a scan cycle is valid in the next one
        r_rdv    <= i_rst_n && r_state == S_SCAN;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_minb  <= 16'd2048;
        end else begin
            if (i_cfg_we) r_minb <= i_cfg_wdata;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (LEVELS+1)'(NN-1)) r_state <= S_IDLE;
                end
                S_IDLE: if (start) begin
                    r_op <= i_op; r_bytes <= i_request_bytes; r_node <= i_free_node;
                    r_found <= '0; r_lvl <= '0; r_off <= '0;
                    if (i_op == bba_pkg::OP_FREE) begin
                        if (i_free_node == '0) begin
                            r_status <= bba_pkg::ST_INVALID; r_state <= S_DONE;
                        end else begin
                            r_status <= bba_pkg::ST_FREED;
                            r_cur <= i_free_node; r_state <= S_WALK;
                        end
                    end else begin
                        r_status <= bba_pkg::ST_NOBLOCK;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (w_div_done) begin
                    if (w_quot == '0) r_state <= S_DONE;
                    else begin
                        r_cur <= LEVELS'((NW'(1) << ({1'b0, w_qlvl} + 1'b1)) - 1'b1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read issued at r_cur; data arrives in the next cycle
                    if (r_rdv && r_rd) begin
                        r_found <= r_cur + 1'b1; r_node <= r_cur + 1'b1;
                        r_cur <= r_cur + 1'b1;
                        r_status <= bba_pkg::ST_ALLOC;
                        r_lvl <= node_lvl(r_cur + 1'b1);
                        r_state <= S_ANC;
                    end else if (r_rdv && r_cur == LEVELS'(0)) begin
                        r_state <= S_DONE;
                    end else if (r_cur != '0) begin
                        r_cur <= r_cur - 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ANC: begin
                    r_cur <= r_cur >> 1;
                    if (r_cur == LEVELS'(1)) begin
                        r_k <= '0; r_cnt <= '0; r_state <= S_SUB;
                    end
                end
                S_WALK: begin
                    // node written free; buddy read issued
                    if (r_cur == LEVELS'(1)) begin
                        r_k <= '0; r_cnt <= '0; r_state <= S_SUB;
                    end else r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (r_rd) begin
                        r_cur <= r_cur >> 1; r_state <= S_WALK;
                    end else begin
                        r_k <= '0; r_cnt <= '0; r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_cnt == ((LEVELS+1)'(1) << r_k) - 1'b1) begin
                        r_cnt <= '0;
                        if (w_sub_lvl >= LW'(LEVELS-1)) begin
                            r_state <= (r_op == bba_pkg::OP_FREE) ? S_DONE : S_OFF;
                            r_off <= 48'(r_node - (LEVELS'(1) << r_lvl))
                                     << (LEVELS - r_lvl);
                        end else r_k <= r_k + 1'b1;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                S_OFF: begin
                    r_off <= 48'(r_off[31:0] * 32'(r_minb));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_sub_val = (r_state == S_SUB);
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_val;
    assign o_status       = r_status;
    assign o_node_index   = r_found;
    assign o_block_level  = r_lvl;
    assign o_block_offset = (r_status == bba_pkg::ST_ALLOC) ? r_off[23:0] : 24'd0;

    `ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_state == S_DONE, o_valid)
    `ASSERT_IMPL(a_sub_write, i_clk, i_rst_n, w_sub_val, w_we)
endmodule
